@@ design/noise_floor_trimmed_average_unit_assert.svh @@
`ifndef NOISE_FLOOR_TRIMMED_AVERAGE_UNIT_ASSERT_SVH
`define NOISE_FLOOR_TRIMMED_AVERAGE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define NFTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nfta assertion failed");
`define NFTA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nfta assertion failed");
`else
`define NFTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define NFTA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ design/nfta_pkg.sv @@
package nfta_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DW           = 8;
  localparam int CHAN_W       = 8;
  localparam int CNT_W        = 32;
  localparam int ACC_W        = CNT_W + DW + 1;
  localparam int DQ_W         = DW + 1;
  localparam int STEP_W       = $clog2(DQ_W);
  localparam int CFG_IDX_W    = 2;

  localparam logic [CHAN_W:0] CH_LIM = (CHAN_W + 1)'(NUM_CHANNELS);

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CHANNEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_CHANNEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_NOISE   = 2'd2;

  localparam logic [CHAN_W-1:0] FIRST_CHANNEL_RST = 8'd1;
  localparam logic [CHAN_W-1:0] LAST_CHANNEL_RST  = 8'd13;
  localparam logic [DW-1:0]     RESET_NOISE_RST   = 8'hA1;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_RESET  = 1'b1;

  typedef struct packed {
    logic load;
    logic settle;
    logic mul;
    logic prep;
    logic div_step;
    logic commit;
  } nfta_cmd_t;

  typedef struct packed {
    logic full;
    logic div_last;
  } nfta_stat_t;

endpackage

@@ design/noise_floor_trimmed_average_unit.sv @@
// Channel   Handshake              Payload
// input     start / busy           in_mode, in_channel, in_noise_dbm
// result    out_strobe (1 cycle)   out_result_dbm, out_in_range, out_max_dbm,
//                                  out_min_dbm, out_avg_dbm
// config    cfg_we                 cfg_index, cfg_wdata
//
// A sample on an in-range channel that holds both max and min passes from
// EVAL through MUL, PREP and the quotient loop of the divider in DIV to
// FIN before the result strobe; every other item goes from EVAL to FIN.
// The next item transfers in the strobe cycle. The receiver cannot stall.
// Synchronous active-low reset clears tables and counter, restores config.
module noise_floor_trimmed_average_unit import nfta_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic        [CFG_IDX_W-1:0] cfg_index,
  input  logic        [DW-1:0]        cfg_wdata,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_mode,
  input  logic        [CHAN_W-1:0]    in_channel,
  input  logic signed [DW-1:0]        in_noise_dbm,
  output logic                        out_strobe,
  output logic signed [DW-1:0]        out_result_dbm,
  output logic                        out_in_range,
  output logic signed [DW-1:0]        out_max_dbm,
  output logic signed [DW-1:0]        out_min_dbm,
  output logic signed [DW-1:0]        out_avg_dbm
);

  nfta_cmd_t  cmd;
  nfta_stat_t stat;

  nfta_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd),
    .stat       (stat)
  );

  nfta_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_mode        (in_mode),
    .in_channel     (in_channel),
    .in_noise_dbm   (in_noise_dbm),
    .out_result_dbm (out_result_dbm),
    .out_in_range   (out_in_range),
    .out_max_dbm    (out_max_dbm),
    .out_min_dbm    (out_min_dbm),
    .out_avg_dbm    (out_avg_dbm)
  );

endmodule

@@ design/nfta_ctrl.sv @@
`include "noise_floor_trimmed_average_unit_assert.svh"

module nfta_ctrl import nfta_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  output logic       out_strobe,
  output nfta_cmd_t  cmd,
  input  nfta_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_strobe_r, out_strobe_nxt;

  always_comb begin
    state_nxt      = state_r;
    out_strobe_nxt = 1'b0;
    cmd            = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.settle = 1'b1;
        state_nxt  = stat.full ? ST_MUL : ST_FIN;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.commit     = 1'b1;
        out_strobe_nxt = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;

  `NFTA_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_strobe_r, state_r == ST_IDLE)
  `NFTA_ASSERT_NXT(a_start_eval, clk, rst_n, start && (state_r == ST_IDLE), state_r == ST_EVAL)
  `NFTA_ASSERT_NXT(a_div_hold, clk, rst_n, (state_r == ST_DIV) && !stat.div_last, state_r == ST_DIV)

endmodule

@@ design/nfta_dp.sv @@
module nfta_dp import nfta_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nfta_cmd_t                   cmd,
  output nfta_stat_t                  stat,
  input  logic                        cfg_we,
  input  logic        [CFG_IDX_W-1:0] cfg_index,
  input  logic        [DW-1:0]        cfg_wdata,
  input  logic                        in_mode,
  input  logic        [CHAN_W-1:0]    in_channel,
  input  logic signed [DW-1:0]        in_noise_dbm,
  output logic signed [DW-1:0]        out_result_dbm,
  output logic                        out_in_range,
  output logic signed [DW-1:0]        out_max_dbm,
  output logic signed [DW-1:0]        out_min_dbm,
  output logic signed [DW-1:0]        out_avg_dbm
);

  logic        [CHAN_W-1:0] first_r, last_r;
  logic signed [DW-1:0]     rn_r;

  logic signed [DW-1:0] max_tbl_r [NUM_CHANNELS];
  logic signed [DW-1:0] min_tbl_r [NUM_CHANNELS];
  logic signed [DW-1:0] avg_tbl_r [NUM_CHANNELS];
  logic        [CNT_W-1:0] count_r;

  logic                    mode_r, inr_r, neg_r;
  logic        [IDX_W-1:0] idx_r;
  logic signed [DW-1:0]    smp_r, mx_r, mn_r, avg_r;
  logic signed [DW-1:0]    nmx_r, nmn_r, navg_r, med_r, res_r;
  logic signed [ACC_W-1:0] prod_r;
  logic        [ACC_W-1:0] rem_r, dv_r;
  logic        [DQ_W-1:0]  q_r;
  logic        [STEP_W-1:0] step_r;

  logic signed [DW-1:0] out_res_r, out_max_r, out_min_r, out_avg_r;
  logic                 out_inr_r;

  logic        [CHAN_W-1:0] diff;
  logic                     in_ok;
  logic        [IDX_W-1:0]  in_idx;
  logic                     hi_swap, lo_swap;
  logic signed [DW-1:0]     cur1, fmx, fmn, med;
  logic        [CNT_W-1:0]  cnt_m1;
  logic signed [CNT_W:0]    mul_a;
  logic signed [ACC_W-1:0]  acc;
  logic                     ge;
  logic        [DQ_W-1:0]   q_nxt;

  assign diff   = in_channel - first_r;
  assign in_ok  = (in_channel >= first_r) && (in_channel <= last_r) && ({1'b0, diff} < CH_LIM);
  assign in_idx = diff[IDX_W-1:0];

  assign hi_swap = smp_r > mx_r;
  assign cur1    = hi_swap ? mx_r : smp_r;
  assign fmx     = hi_swap ? smp_r : mx_r;
  assign lo_swap = cur1 < mn_r;
  assign fmn     = lo_swap ? cur1 : mn_r;
  assign med     = lo_swap ? mn_r : cur1;

  assign cnt_m1 = count_r - CNT_W'(1);
  assign mul_a  = $signed({1'b0, cnt_m1});
  assign acc    = prod_r + ACC_W'(med_r);
  assign ge     = rem_r >= dv_r;
  assign q_nxt  = {q_r[DQ_W-2:0], ge};

  assign stat.full     = inr_r && (mode_r == MODE_SAMPLE) && (mx_r != '0) && (mn_r != '0);
  assign stat.div_last = (step_r == '0);

  // Configuration, sample counter and tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= FIRST_CHANNEL_RST;
      last_r  <= LAST_CHANNEL_RST;
      rn_r    <= RESET_NOISE_RST;
      count_r <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        max_tbl_r[i] <= '0;
        min_tbl_r[i] <= '0;
        avg_tbl_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST_CHANNEL: first_r <= cfg_wdata;
          CFG_LAST_CHANNEL:  last_r  <= cfg_wdata;
          CFG_RESET_NOISE:   rn_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.settle && inr_r) begin
        if (mode_r == MODE_RESET) begin
          count_r <= '0;
        end else if (stat.full && (count_r != '1)) begin
          count_r <= count_r + CNT_W'(1);
        end
      end
      if (cmd.commit && inr_r) begin
        max_tbl_r[idx_r] <= nmx_r;
        min_tbl_r[idx_r] <= nmn_r;
        avg_tbl_r[idx_r] <= navg_r;
      end
    end
  end

  // Item payload and arithmetic
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      inr_r  <= in_ok;
      idx_r  <= in_idx;
      smp_r  <= in_noise_dbm;
      mx_r   <= max_tbl_r[in_idx];
      mn_r   <= min_tbl_r[in_idx];
      avg_r  <= avg_tbl_r[in_idx];
    end
    if (cmd.settle) begin
      res_r <= (mode_r == MODE_RESET) ? rn_r : smp_r;
      if (mode_r == MODE_RESET) begin
        nmx_r  <= '0;
        nmn_r  <= '0;
        navg_r <= rn_r;
      end else if (mx_r == '0) begin
        nmx_r  <= smp_r;
        nmn_r  <= mn_r;
        navg_r <= smp_r;
      end else if (mn_r == '0) begin
        nmx_r  <= fmx;
        nmn_r  <= cur1;
        navg_r <= cur1;
      end else begin
        nmx_r <= fmx;
        nmn_r <= fmn;
        med_r <= med;
      end
    end
    if (cmd.mul) begin
      prod_r <= mul_a * avg_r;
    end
    if (cmd.prep) begin
      neg_r  <= acc[ACC_W-1];
      rem_r  <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
      dv_r   <= ACC_W'(count_r) << (DQ_W - 1);
      q_r    <= '0;
      step_r <= STEP_W'(DQ_W - 1);
    end
    if (cmd.div_step) begin
      rem_r  <= ge ? (rem_r - dv_r) : rem_r;
      dv_r   <= dv_r >> 1;
      q_r    <= q_nxt;
      step_r <= step_r - STEP_W'(1);
      if (stat.div_last) begin
        navg_r <= neg_r ? DW'(-q_nxt) : DW'(q_nxt);
      end
    end
    if (cmd.commit) begin
      out_inr_r <= inr_r;
      out_res_r <= inr_r ? res_r  : '0;
      out_max_r <= inr_r ? nmx_r  : '0;
      out_min_r <= inr_r ? nmn_r  : '0;
      out_avg_r <= inr_r ? navg_r : '0;
    end
  end

  assign out_result_dbm = out_res_r;
  assign out_in_range   = out_inr_r;
  assign out_max_dbm    = out_max_r;
  assign out_min_dbm    = out_min_r;
  assign out_avg_dbm    = out_avg_r;

endmodule
